FILE: src/gapf_pkg.sv
// Shared types, constants and codes of the grid A* path finder.
package gapf_pkg;

   localparam int GRID_W_DEF = 8;
   localparam int GRID_H_DEF = 8;
   localparam int MAX_PATH = 64;
   localparam logic [14:0] SQRT2_Q14 = 15'd23170;
   localparam logic [14:0] UNIT_Q14 = 15'd16384;
   localparam logic [15:0] COST_ONE = 16'd256;
   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

   localparam logic [1:0] FUNC_BLOCK = 2'd0;
   localparam logic [1:0] FUNC_COST = 2'd1;
   localparam logic [1:0] FUNC_PATH = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [2:0] STS_OK = 3'd0;
   localparam logic [2:0] STS_START_OUT = 3'd1;
   localparam logic [2:0] STS_GOAL_OUT = 3'd2;
   localparam logic [2:0] STS_GOAL_BLOCKED = 3'd3;
   localparam logic [2:0] STS_UNREACHABLE = 3'd4;
   localparam logic [2:0] STS_REJECTED = 3'd5;

   localparam logic CSR_GRID_WIDTH = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam logic signed [1:0] STEP_DX [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                                 2'sd1, 2'sd1, -2'sd1, -2'sd1};
   localparam logic signed [1:0] STEP_DY [8] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                                 2'sd1, -2'sd1, 2'sd1, -2'sd1};

   typedef enum logic [4:0] {
      OP_WAIT, OP_IDLE, OP_MAP_CLR, OP_DECODE, OP_GCHK, OP_NODE_CLR, OP_INIT,
      OP_SCAN0, OP_SCAN, OP_SCAN_END, OP_POP, OP_CUR, OP_DIR, OP_SIDE1, OP_SIDE2,
      OP_NB, OP_RND, OP_REL, OP_KRD, OP_KCHK, OP_TWR, OP_TRD, OP_TCHK, OP_ERD,
      OP_EOUT, OP_SEND1
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_MAP_CLR, ST_IDLE, ST_DECODE, ST_GCHK, ST_NODE_CLR, ST_INIT, ST_SCAN0,
      ST_SCAN, ST_SCAN_END, ST_POP, ST_CUR, ST_DIR, ST_SIDE1, ST_SIDE2, ST_NB,
      ST_RND, ST_REL, ST_KRD, ST_KCHK, ST_TWR, ST_TRD, ST_TCHK, ST_ERD, ST_EOUT,
      ST_SEND1
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic req_xfer;
      logic cfg_clear;
      logic cnt_last;
      logic path_ok;
      logic blk_rd;
      logic best_valid;
      logic best_goal;
      logic nb_in;
      logic is_diag;
      logic dir_last;
      logic known_rd;
      logic trail_full;
      logic at_start;
      logic too_long;
      logic n_zero;
      logic rsp_free;
   } dp_sts_type;

endpackage

FILE: src/gapf_ctrl.sv
// Sequencer of the path finder: steps the datapath through clear, search and path output.
module gapf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  gapf_pkg::dp_sts_type sts,
   output gapf_pkg::dp_cmd_type cmd
);
   import gapf_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MAP_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_MAP_CLR: begin
            if (!sts.cfg_clear && sts.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (sts.req_xfer) state_in = ST_DECODE;
            else if (sts.cfg_clear) state_in = ST_MAP_CLR;
         end
         ST_DECODE: state_in = sts.path_ok ? ST_GCHK : ST_SEND1;
         ST_GCHK: state_in = sts.blk_rd ? ST_SEND1 : ST_NODE_CLR;
         ST_NODE_CLR: begin
            if (sts.cnt_last) state_in = ST_INIT;
         end
         ST_INIT: state_in = ST_SCAN0;
         ST_SCAN0: state_in = ST_SCAN;
         ST_SCAN: begin
            if (sts.cnt_last) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: state_in = ST_POP;
         ST_POP: state_in = (!sts.best_valid || sts.best_goal) ? ST_KRD : ST_CUR;
         ST_CUR: state_in = ST_DIR;
         ST_DIR: begin
            if (!sts.nb_in) state_in = sts.dir_last ? ST_SCAN0 : ST_DIR;
            else state_in = sts.is_diag ? ST_SIDE1 : ST_NB;
         end
         ST_SIDE1: begin
            if (sts.blk_rd) state_in = sts.dir_last ? ST_SCAN0 : ST_DIR;
            else state_in = ST_SIDE2;
         end
         ST_SIDE2: begin
            if (sts.blk_rd) state_in = sts.dir_last ? ST_SCAN0 : ST_DIR;
            else state_in = ST_NB;
         end
         ST_NB: begin
            if (sts.blk_rd) state_in = sts.dir_last ? ST_SCAN0 : ST_DIR;
            else state_in = ST_RND;
         end
         ST_RND: state_in = ST_REL;
         ST_REL: state_in = sts.dir_last ? ST_SCAN0 : ST_DIR;
         ST_KRD: state_in = ST_KCHK;
         ST_KCHK: state_in = sts.known_rd ? ST_TWR : ST_SEND1;
         ST_TWR: begin
            priority if (sts.trail_full) state_in = ST_SEND1;
            else if (sts.at_start) state_in = ST_TCHK;
            else state_in = ST_TRD;
         end
         ST_TRD: state_in = ST_TWR;
         ST_TCHK: state_in = sts.too_long ? ST_SEND1 : ST_ERD;
         ST_ERD: state_in = ST_EOUT;
         ST_EOUT: begin
            if (sts.rsp_free) state_in = sts.n_zero ? ST_IDLE : ST_ERD;
         end
         ST_SEND1: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_WAIT;
      unique case (state_ff)
         ST_MAP_CLR:  cmd.op = OP_MAP_CLR;
         ST_IDLE:     cmd.op = OP_IDLE;
         ST_DECODE:   cmd.op = OP_DECODE;
         ST_GCHK:     cmd.op = OP_GCHK;
         ST_NODE_CLR: cmd.op = OP_NODE_CLR;
         ST_INIT:     cmd.op = OP_INIT;
         ST_SCAN0:    cmd.op = OP_SCAN0;
         ST_SCAN:     cmd.op = OP_SCAN;
         ST_SCAN_END: cmd.op = OP_SCAN_END;
         ST_POP:      cmd.op = OP_POP;
         ST_CUR:      cmd.op = OP_CUR;
         ST_DIR:      cmd.op = OP_DIR;
         ST_SIDE1:    cmd.op = OP_SIDE1;
         ST_SIDE2:    cmd.op = OP_SIDE2;
         ST_NB:       cmd.op = OP_NB;
         ST_RND:      cmd.op = OP_RND;
         ST_REL:      cmd.op = OP_REL;
         ST_KRD:      cmd.op = OP_KRD;
         ST_KCHK:     cmd.op = OP_KCHK;
         ST_TWR:      cmd.op = OP_TWR;
         ST_TRD:      cmd.op = OP_TRD;
         ST_TCHK:     cmd.op = OP_TCHK;
         ST_ERD:      cmd.op = OP_ERD;
         ST_EOUT:     cmd.op = OP_EOUT;
         ST_SEND1:    cmd.op = OP_SEND1;
         default:     cmd.op = OP_WAIT;
      endcase
   end

endmodule

FILE: src/gapf_datapath.sv
// Datapath of the path finder: maps, search memories, cost arithmetic and result register.
module gapf_datapath #(
   parameter int GRID_W = gapf_pkg::GRID_W_DEF,
   parameter int GRID_H = gapf_pkg::GRID_H_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gapf_pkg::dp_cmd_type cmd,
   output gapf_pkg::dp_sts_type sts,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_func,
   input  logic [3:0]           req_cell_x,
   input  logic [3:0]           req_cell_y,
   input  logic                 req_block_flag,
   input  logic [15:0]          req_cost_value,
   input  logic [3:0]           req_goal_x,
   input  logic [3:0]           req_goal_y,
   input  logic                 req_allow_diagonal,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [2:0]           rsp_path_x,
   output logic [2:0]           rsp_path_y,
   output logic                 rsp_last,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [3:0]           csr_wdata
);
   import gapf_pkg::*;

   localparam int NCELLS = GRID_W * GRID_H;
   localparam int CW = $clog2(NCELLS);
   localparam int XW = $clog2(GRID_W);
   localparam int YW = $clog2(GRID_H);
   localparam int GWW = $clog2(GRID_W + 1);
   localparam int GHW = $clog2(GRID_H + 1);

   typedef struct packed {
      logic [23:0] gdist;
      logic [23:0] prio;
      logic [3:0]  fx;
      logic [3:0]  fy;
   } node_type;

   dp_op_type op;

   logic [GWW-1:0] gw_ff, gw_in;
   logic [GHW-1:0] gh_ff, gh_in;
   logic [1:0]     func_ff, func_in;
   logic [3:0]     sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic           bflag_ff, bflag_in, diag_ff, diag_in;
   logic [15:0]    cost_ff, cost_in;
   logic [2:0]     status_ff, status_in;
   logic [CW:0]    cnt_ff, cnt_in;
   logic [XW-1:0]  scan_x_ff, scan_x_in;
   logic [YW-1:0]  scan_y_ff, scan_y_in;
   logic           prev_ok_ff, prev_ok_in;
   logic [3:0]     prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic           best_v_ff, best_v_in;
   logic [3:0]     best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [23:0]    best_p_ff, best_p_in;
   logic [3:0]     cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [23:0]    curdist_ff, curdist_in;
   logic [2:0]     dir_ff, dir_in;
   logic [30:0]    prod_ff, prod_in;
   logic [23:0]    cand_ff, cand_in;
   logic [CW-1:0]  n_ff, n_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [2:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           blk_mem [NCELLS];
   logic [15:0]    cost_mem [NCELLS];
   logic [1:0]     flag_mem [NCELLS];
   node_type       node_mem [NCELLS];
   logic [7:0]     trail_mem [NCELLS];
   logic           blk_rd_ff;
   logic [15:0]    cost_rd_ff;
   logic [1:0]     flag_rd_ff;
   node_type       node_rd_ff;
   logic [7:0]     trail_rd_ff;

   logic           blk_re, blk_we, blk_wd, cost_re, cost_we, flag_re, flag_we;
   logic           node_re, node_we, trail_re, trail_we;
   logic [CW-1:0]  blk_ra, blk_wa, cost_wa, flag_ra, flag_wa, node_ra, node_wa;
   logic [CW-1:0]  trail_ra, trail_wa;
   logic [15:0]    cost_wd;
   logic [1:0]     flag_wd;
   node_type       node_wd;
   logic [7:0]     trail_wd;

   logic           req_xfer, cfg_clear, rsp_free, s_in, g_in, nb_in, is_diag;
   logic [2:0]     code;
   logic signed [5:0] nx_s, ny_s;
   logic [3:0]     nx4, ny4, hdx, hdy;
   logic [12:0]    heur;
   logic [16:0]    step;
   logic [24:0]    dsum, psum;
   logic [23:0]    prio_new;
   logic           relax_go, scan_hit;
   logic [CW-1:0]  nb_idx, side1_idx, side2_idx, goal_idx, start_idx, best_idx;
   logic [CW-1:0]  cur_idx, cnt_idx;

   function automatic logic [CW-1:0] cell_idx(input logic [3:0] x, input logic [3:0] y);
      cell_idx = CW'(int'(y) * GRID_W + int'(x));
   endfunction

   assign op = cmd.op;
   assign req_ready = (op == OP_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign cfg_clear = csr_we && (csr_wdata != 4'd0) &&
                      (((csr_index == CSR_GRID_WIDTH) && (int'(csr_wdata) <= GRID_W)) ||
                       ((csr_index == CSR_GRID_HEIGHT) && (int'(csr_wdata) <= GRID_H)));

   assign s_in = (int'(sx_ff) < int'(gw_ff)) && (int'(sy_ff) < int'(gh_ff));
   assign g_in = (int'(gx_ff) < int'(gw_ff)) && (int'(gy_ff) < int'(gh_ff));

   always_comb begin
      unique case (func_ff)
         FUNC_BLOCK: code = s_in ? STS_OK : STS_REJECTED;
         FUNC_COST:  code = (s_in && (cost_ff >= COST_ONE)) ? STS_OK : STS_REJECTED;
         FUNC_PATH: begin
            priority if (!s_in) code = STS_START_OUT;
            else if (!g_in) code = STS_GOAL_OUT;
            else code = STS_OK;
         end
         default: code = STS_REJECTED;
      endcase
   end

   assign nx_s = $signed({2'b00, cur_x_ff}) + 6'(STEP_DX[dir_ff]);
   assign ny_s = $signed({2'b00, cur_y_ff}) + 6'(STEP_DY[dir_ff]);
   assign nx4 = nx_s[3:0];
   assign ny4 = ny_s[3:0];
   assign nb_in = (nx_s >= 0) && (int'(nx_s) < int'(gw_ff)) &&
                  (ny_s >= 0) && (int'(ny_s) < int'(gh_ff));
   assign is_diag = dir_ff[2];

   assign hdx = (gx_ff > nx4) ? (gx_ff - nx4) : (nx4 - gx_ff);
   assign hdy = (gy_ff > ny4) ? (gy_ff - ny4) : (ny4 - gy_ff);
   assign heur = {{1'b0, hdx} + {1'b0, hdy}, 8'd0};

   assign step = 17'((prod_ff + 31'd8192) >> 14);
   assign dsum = {1'b0, curdist_ff} + {8'd0, step};
   assign psum = {1'b0, cand_ff} + {12'd0, heur};
   assign prio_new = (psum > {1'b0, DIST_MAX}) ? DIST_MAX : psum[23:0];
   assign relax_go = !(flag_rd_ff[0] && (cand_ff >= node_rd_ff.gdist));
   assign scan_hit = prev_ok_ff && flag_rd_ff[1] &&
                     (!best_v_ff || (node_rd_ff.prio < best_p_ff));

   assign nb_idx = cell_idx(nx4, ny4);
   assign side1_idx = cell_idx(nx4, cur_y_ff);
   assign side2_idx = cell_idx(cur_x_ff, ny4);
   assign goal_idx = cell_idx(gx_ff, gy_ff);
   assign start_idx = cell_idx(sx_ff, sy_ff);
   assign best_idx = cell_idx(best_x_ff, best_y_ff);
   assign cur_idx = cell_idx(cur_x_ff, cur_y_ff);
   assign cnt_idx = cnt_ff[CW-1:0];

   always_comb begin
      sts.req_xfer = req_xfer;
      sts.cfg_clear = cfg_clear;
      sts.cnt_last = (cnt_ff == (CW+1)'(NCELLS - 1));
      sts.path_ok = (func_ff == FUNC_PATH) && (code == STS_OK);
      sts.blk_rd = blk_rd_ff;
      sts.best_valid = best_v_ff;
      sts.best_goal = (best_x_ff == gx_ff) && (best_y_ff == gy_ff);
      sts.nb_in = nb_in;
      sts.is_diag = is_diag;
      sts.dir_last = (dir_ff == (diag_ff ? 3'd7 : 3'd3));
      sts.known_rd = flag_rd_ff[0];
      sts.trail_full = (cnt_ff == (CW+1)'(NCELLS));
      sts.at_start = (cur_x_ff == sx_ff) && (cur_y_ff == sy_ff);
      sts.too_long = (int'(cnt_ff) > MAX_PATH);
      sts.n_zero = (n_ff == '0);
      sts.rsp_free = rsp_free;
   end

   // memory ports
   always_comb begin
      blk_re = 1'b0;   blk_ra = nb_idx;
      blk_we = 1'b0;   blk_wa = cnt_idx;   blk_wd = 1'b0;
      cost_re = 1'b0;
      cost_we = 1'b0;  cost_wa = cnt_idx;  cost_wd = COST_ONE;
      flag_re = 1'b0;  flag_ra = nb_idx;
      flag_we = 1'b0;  flag_wa = cnt_idx;  flag_wd = 2'b00;
      node_re = 1'b0;  node_ra = nb_idx;
      node_we = 1'b0;  node_wa = nb_idx;
      node_wd = '{gdist: cand_ff, prio: prio_new, fx: cur_x_ff, fy: cur_y_ff};
      trail_re = 1'b0; trail_ra = n_ff;
      trail_we = 1'b0; trail_wa = cnt_idx; trail_wd = {cur_y_ff, cur_x_ff};
      unique case (op)
         OP_MAP_CLR: begin
            blk_we = 1'b1;
            cost_we = 1'b1;
         end
         OP_DECODE: begin
            blk_re = 1'b1;
            blk_ra = goal_idx;
            blk_wa = start_idx;
            blk_wd = bflag_ff;
            cost_wa = start_idx;
            cost_wd = cost_ff;
            blk_we = (code == STS_OK) && (func_ff == FUNC_BLOCK);
            cost_we = (code == STS_OK) && (func_ff == FUNC_COST);
         end
         OP_NODE_CLR: flag_we = 1'b1;
         OP_INIT: begin
            flag_we = 1'b1;
            flag_wa = start_idx;
            flag_wd = 2'b11;
            node_we = 1'b1;
            node_wa = start_idx;
            node_wd = '{gdist: 24'd0, prio: 24'd0, fx: sx_ff, fy: sy_ff};
         end
         OP_SCAN: begin
            flag_re = 1'b1;
            flag_ra = cnt_idx;
            node_re = 1'b1;
            node_ra = cnt_idx;
         end
         OP_POP: begin
            flag_we = best_v_ff;
            flag_wa = best_idx;
            flag_wd = 2'b01;
            node_re = 1'b1;
            node_ra = best_idx;
         end
         OP_DIR: begin
            if (nb_in) begin
               if (is_diag) begin
                  blk_re = 1'b1;
                  blk_ra = side1_idx;
               end else begin
                  blk_re = 1'b1;
                  cost_re = 1'b1;
                  flag_re = 1'b1;
                  node_re = 1'b1;
               end
            end
         end
         OP_SIDE1: begin
            if (!blk_rd_ff) begin
               blk_re = 1'b1;
               blk_ra = side2_idx;
            end
         end
         OP_SIDE2: begin
            if (!blk_rd_ff) begin
               blk_re = 1'b1;
               cost_re = 1'b1;
               flag_re = 1'b1;
               node_re = 1'b1;
            end
         end
         OP_REL: begin
            node_we = relax_go;
            flag_we = relax_go;
            flag_wa = nb_idx;
            flag_wd = 2'b11;
         end
         OP_KRD: begin
            flag_re = 1'b1;
            flag_ra = goal_idx;
         end
         OP_TWR: begin
            if (!sts.trail_full) begin
               trail_we = 1'b1;
               node_re = 1'b1;
               node_ra = cur_idx;
            end
         end
         OP_ERD: trail_re = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (blk_we) blk_mem[blk_wa] <= blk_wd;
      if (blk_re) blk_rd_ff <= blk_mem[blk_ra];
   end

   always_ff @(posedge clock) begin
      if (cost_we) cost_mem[cost_wa] <= cost_wd;
      if (cost_re) cost_rd_ff <= cost_mem[nb_idx];
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_wa] <= flag_wd;
      if (flag_re) flag_rd_ff <= flag_mem[flag_ra];
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_wa] <= node_wd;
      if (node_re) node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (trail_we) trail_mem[trail_wa] <= trail_wd;
      if (trail_re) trail_rd_ff <= trail_mem[trail_ra];
   end

   // next values of the working registers
   always_comb begin
      gw_in = gw_ff;           gh_in = gh_ff;
      func_in = func_ff;       sx_in = sx_ff;       sy_in = sy_ff;
      gx_in = gx_ff;           gy_in = gy_ff;       bflag_in = bflag_ff;
      diag_in = diag_ff;       cost_in = cost_ff;   status_in = status_ff;
      cnt_in = cnt_ff;         scan_x_in = scan_x_ff; scan_y_in = scan_y_ff;
      prev_ok_in = prev_ok_ff; prev_x_in = prev_x_ff; prev_y_in = prev_y_ff;
      best_v_in = best_v_ff;   best_x_in = best_x_ff; best_y_in = best_y_ff;
      best_p_in = best_p_ff;   cur_x_in = cur_x_ff; cur_y_in = cur_y_ff;
      curdist_in = curdist_ff; dir_in = dir_ff;     prod_in = prod_ff;
      cand_in = cand_ff;       n_in = n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_x_in = rsp_x_ff;     rsp_y_in = rsp_y_ff; rsp_last_in = rsp_last_ff;

      unique case (op)
         OP_IDLE: begin
            if (req_xfer) begin
               func_in = req_func;
               sx_in = req_cell_x;
               sy_in = req_cell_y;
               bflag_in = req_block_flag;
               cost_in = req_cost_value;
               gx_in = req_goal_x;
               gy_in = req_goal_y;
               diag_in = req_allow_diagonal;
            end
         end
         OP_MAP_CLR, OP_NODE_CLR: cnt_in = cnt_ff + 1'b1;
         OP_DECODE: status_in = code;
         OP_GCHK: begin
            cnt_in = '0;
            if (blk_rd_ff) status_in = STS_GOAL_BLOCKED;
         end
         OP_SCAN0: begin
            cnt_in = '0;
            scan_x_in = '0;
            scan_y_in = '0;
            prev_ok_in = 1'b0;
            best_v_in = 1'b0;
         end
         OP_SCAN, OP_SCAN_END: begin
            if (scan_hit) begin
               best_v_in = 1'b1;
               best_x_in = prev_x_ff;
               best_y_in = prev_y_ff;
               best_p_in = node_rd_ff.prio;
            end
            if (op == OP_SCAN) begin
               prev_ok_in = 1'b1;
               prev_x_in = 4'(scan_x_ff);
               prev_y_in = 4'(scan_y_ff);
               cnt_in = cnt_ff + 1'b1;
               if (int'(scan_x_ff) == GRID_W - 1) begin
                  scan_x_in = '0;
                  scan_y_in = scan_y_ff + 1'b1;
               end else begin
                  scan_x_in = scan_x_ff + 1'b1;
               end
            end else begin
               prev_ok_in = 1'b0;
            end
         end
         OP_POP: begin
            cur_x_in = best_x_ff;
            cur_y_in = best_y_ff;
            dir_in = 3'd0;
         end
         OP_CUR: curdist_in = node_rd_ff.gdist;
         OP_DIR: begin
            if (!nb_in) dir_in = dir_ff + 1'b1;
         end
         OP_SIDE1, OP_SIDE2: begin
            if (blk_rd_ff) dir_in = dir_ff + 1'b1;
         end
         OP_NB: begin
            if (blk_rd_ff) dir_in = dir_ff + 1'b1;
            else prod_in = 31'(cost_rd_ff) * 31'(is_diag ? SQRT2_Q14 : UNIT_Q14);
         end
         OP_RND: cand_in = (dsum > {1'b0, DIST_MAX}) ? DIST_MAX : dsum[23:0];
         OP_REL: dir_in = dir_ff + 1'b1;
         OP_KCHK: begin
            cnt_in = '0;
            cur_x_in = gx_ff;
            cur_y_in = gy_ff;
            if (!flag_rd_ff[0]) status_in = STS_UNREACHABLE;
         end
         OP_TWR: begin
            if (sts.trail_full) status_in = STS_UNREACHABLE;
            else cnt_in = cnt_ff + 1'b1;
         end
         OP_TRD: begin
            cur_x_in = node_rd_ff.fx;
            cur_y_in = node_rd_ff.fy;
         end
         OP_TCHK: begin
            n_in = CW'(cnt_ff - 1'b1);
            if (sts.too_long) status_in = STS_UNREACHABLE;
         end
         OP_EOUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STS_OK;
               rsp_x_in = trail_rd_ff[2:0];
               rsp_y_in = trail_rd_ff[6:4];
               rsp_last_in = (n_ff == '0);
               n_in = n_ff - 1'b1;
            end
         end
         OP_SEND1: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_x_in = 3'd0;
               rsp_y_in = 3'd0;
               rsp_last_in = 1'b1;
            end
         end
         default: ;
      endcase

      if (csr_we && cfg_clear) begin
         cnt_in = '0;
         if (csr_index == CSR_GRID_WIDTH) gw_in = GWW'(csr_wdata);
         else gh_in = GHW'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= GWW'(GRID_W);
         gh_ff <= GHW'(GRID_H);
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         prev_ok_ff <= 1'b0;
         best_v_ff <= 1'b0;
      end else begin
         gw_ff <= gw_in;
         gh_ff <= gh_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ok_ff <= prev_ok_in;
         best_v_ff <= best_v_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;       sx_ff <= sx_in;         sy_ff <= sy_in;
      gx_ff <= gx_in;           gy_ff <= gy_in;         bflag_ff <= bflag_in;
      diag_ff <= diag_in;       cost_ff <= cost_in;     status_ff <= status_in;
      scan_x_ff <= scan_x_in;   scan_y_ff <= scan_y_in;
      prev_x_ff <= prev_x_in;   prev_y_ff <= prev_y_in;
      best_x_ff <= best_x_in;   best_y_ff <= best_y_in; best_p_ff <= best_p_in;
      cur_x_ff <= cur_x_in;     cur_y_ff <= cur_y_in;   curdist_ff <= curdist_in;
      dir_ff <= dir_in;         prod_ff <= prod_in;     cand_ff <= cand_in;
      n_ff <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff <= rsp_x_in;     rsp_y_ff <= rsp_y_in;   rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_path_x = rsp_x_ff;
   assign rsp_path_y = rsp_y_ff;
   assign rsp_last = rsp_last_ff;

endmodule

FILE: src/grid_astar_path_finder_unit.sv
// Top level of the grid A* path finder: sequencer plus datapath.
//
// Request channel (req_*): func 0 writes a blocked flag, func 1 a Q8.8 step cost,
// func 2 asks for a path from (cell_x,cell_y) to (goal_x,goal_y). One transfer is
// taken at a time; req_ready is high only while the unit waits for work.
// Response channel (rsp_*): writes and errors give one transfer with last set;
// a path gives one transfer per cell from start to goal, last on the goal cell.
// The response register holds a result while rsp_ready is low and the unit waits.
// csr_we with csr_index 0/1 sets the grid width/height; in idle a legal value clears
// both maps before the next request is taken. After reset the same clearing sweep runs.
// A search first clears the search flags of all cells, then for each expanded cell
// scans the open set (one read of the flag and node memories per cell), pops the
// best cell and checks each neighbor, then traces the path back from the goal and
// sends the path cells. The open-set scan dominates the search time.
module grid_astar_path_finder_unit #(
   parameter int GRID_W = gapf_pkg::GRID_W_DEF,
   parameter int GRID_H = gapf_pkg::GRID_H_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_cell_x,
   input  logic [3:0]  req_cell_y,
   input  logic        req_block_flag,
   input  logic [15:0] req_cost_value,
   input  logic [3:0]  req_goal_x,
   input  logic [3:0]  req_goal_y,
   input  logic        req_allow_diagonal,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_path_x,
   output logic [2:0]  rsp_path_y,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);
   import gapf_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   gapf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   gapf_datapath #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_cell_x         (req_cell_x),
      .req_cell_y         (req_cell_y),
      .req_block_flag     (req_block_flag),
      .req_cost_value     (req_cost_value),
      .req_goal_x         (req_goal_x),
      .req_goal_y         (req_goal_y),
      .req_allow_diagonal (req_allow_diagonal),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_path_x         (rsp_path_x),
      .rsp_path_y         (rsp_path_y),
      .rsp_last           (rsp_last),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

endmodule

FILE: bench/testbench.sv
// Testbench for the grid A* path finder: directed and random requests checked against a path predictor.
module testbench;
   import gapf_pkg::*;

   localparam int NC = GRID_W_DEF * GRID_H_DEF;
   localparam int IDLE_LIMIT = 40000;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  cx;
      logic [3:0]  cy;
      logic        blk;
      logic [15:0] cost;
      logic [3:0]  gx;
      logic [3:0]  gy;
      logic        diag;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] px;
      logic [2:0] py;
      logic       last;
   } rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [3:0]  req_cell_x = '0;
   logic [3:0]  req_cell_y = '0;
   logic        req_block_flag = 0;
   logic [15:0] req_cost_value = '0;
   logic [3:0]  req_goal_x = '0;
   logic [3:0]  req_goal_y = '0;
   logic        req_allow_diagonal = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_path_x;
   logic [2:0]  rsp_path_y;
   logic        rsp_last;
   logic        csr_we = 0;
   logic        csr_index = 0;
   logic [3:0]  csr_wdata = '0;

   rsp_type path_q[$];
   int   errors = 0;
   bit   quiet = 0;
   int   hold_cycles = 0;
   int   idle_cnt = 0;

   int          grid_w, grid_h;
   logic        blk_map [NC];
   logic [15:0] cost_map [NC];

   always #5 clock = ~clock;

   grid_astar_path_finder_unit dut (.*);

   task automatic report(input string what);
      errors++;
      $display("tb: mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic clear_maps();
      for (int i = 0; i < NC; i++) begin
         blk_map[i] = 0;
         cost_map[i] = COST_ONE;
      end
   endtask

   function automatic bit on_grid(int x, int y);
      return x >= 0 && y >= 0 && x < grid_w && y < grid_h;
   endfunction

   function automatic bit closed(int x, int y);
      return !on_grid(x, y) || blk_map[y * GRID_W_DEF + x];
   endfunction

   function automatic logic [23:0] sat24(logic [23:0] a, logic [23:0] b);
      logic [24:0] s;
      s = a + b;
      return s > DIST_MAX ? DIST_MAX : s[23:0];
   endfunction

   task automatic push_status(input logic [2:0] st);
      path_q.insert(path_q.size(), '{st, 3'd0, 3'd0, 1'b1});
   endtask

   task automatic predict_path(input req_type r);
      logic [23:0] gcost [NC];
      logic [23:0] prio [NC];
      bit          known [NC];
      bit          open [NC];
      int          from [NC];
      int          trail [$];
      int          sx, sy, gx, gy, start, goal, best, cx, cy, nx, ny, ni, cur, dirs;
      logic [31:0] stp;
      logic [23:0] cand;
      sx = r.cx; sy = r.cy; gx = r.gx; gy = r.gy;
      if (!on_grid(sx, sy)) begin push_status(STS_START_OUT); return; end
      if (!on_grid(gx, gy)) begin push_status(STS_GOAL_OUT); return; end
      if (closed(gx, gy)) begin push_status(STS_GOAL_BLOCKED); return; end
      start = sy * GRID_W_DEF + sx;
      goal = gy * GRID_W_DEF + gx;
      for (int i = 0; i < NC; i++) begin
         known[i] = 0; open[i] = 0; gcost[i] = 0; prio[i] = 0; from[i] = 0;
      end
      known[start] = 1;
      open[start] = 1;
      dirs = r.diag ? 8 : 4;
      forever begin
         best = -1;
         for (int i = 0; i < NC; i++)
            if (open[i] && (best < 0 || prio[i] < prio[best])) best = i;
         if (best < 0 || best == goal) break;
         open[best] = 0;
         cx = best % GRID_W_DEF;
         cy = best / GRID_W_DEF;
         for (int d = 0; d < dirs; d++) begin
            nx = cx + STEP_DX[d];
            ny = cy + STEP_DY[d];
            if (closed(nx, ny)) continue;
            if (d >= 4 && (closed(nx, cy) || closed(cx, ny))) continue;
            ni = ny * GRID_W_DEF + nx;
            stp = 32'(cost_map[ni]);
            if (d >= 4) stp = (stp * SQRT2_Q14 + 32'd8192) >> 14;
            cand = sat24(gcost[best], stp[23:0]);
            if (known[ni] && cand >= gcost[ni]) continue;
            gcost[ni] = cand;
            known[ni] = 1;
            from[ni] = best;
            prio[ni] = sat24(cand, 24'((((gx > nx) ? gx - nx : nx - gx) +
                                      ((gy > ny) ? gy - ny : ny - gy)) << 8));
            open[ni] = 1;
         end
      end
      if (!known[goal]) begin push_status(STS_UNREACHABLE); return; end
      cur = goal;
      forever begin
         if (trail.size() >= NC) begin push_status(STS_UNREACHABLE); return; end
         trail.push_front(cur);
         if (cur == start) break;
         cur = from[cur];
      end
      if (trail.size() > MAX_PATH) begin push_status(STS_UNREACHABLE); return; end
      foreach (trail[n])
         path_q.insert(path_q.size(),
                       '{STS_OK, 3'(trail[n] % GRID_W_DEF), 3'(trail[n] / GRID_W_DEF),
                         n == trail.size() - 1});
   endtask

   task automatic predict(input req_type r);
      case (r.func)
         FUNC_BLOCK: begin
            if (!on_grid(r.cx, r.cy)) push_status(STS_REJECTED);
            else begin
               blk_map[r.cy * GRID_W_DEF + r.cx] = r.blk;
               push_status(STS_OK);
            end
         end
         FUNC_COST: begin
            if (!on_grid(r.cx, r.cy) || r.cost < COST_ONE) push_status(STS_REJECTED);
            else begin
               cost_map[r.cy * GRID_W_DEF + r.cx] = r.cost;
               push_status(STS_OK);
            end
         end
         FUNC_PATH: predict_path(r);
         default: push_status(STS_REJECTED);
      endcase
   endtask

   task automatic send(input req_type r);
      int gap;
      gap = (!quiet && $urandom_range(99) < 33) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= r.func;
      req_cell_x <= r.cx;
      req_cell_y <= r.cy;
      req_block_flag <= r.blk;
      req_cost_value <= r.cost;
      req_goal_x <= r.gx;
      req_goal_y <= r.gy;
      req_allow_diagonal <= r.diag;
      do @(posedge clock); while (!req_ready);
      predict(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (path_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [3:0] val);
      drain();
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (val != 0 && val <= (idx == CSR_GRID_WIDTH ? GRID_W_DEF : GRID_H_DEF)) begin
         if (idx == CSR_GRID_WIDTH) grid_w = int'(val);
         else grid_h = int'(val);
         clear_maps();
      end
   endtask

   function automatic req_type mk(logic [1:0] f, int cx, int cy, logic b, logic [15:0] c,
                                  int gx, int gy, logic d);
      return '{f, 4'(cx), 4'(cy), b, c, 4'(gx), 4'(gy), d};
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int      k;
      r = req_type'(36'({$urandom, $urandom}));
      k = $urandom_range(99);
      if (k < 85) begin
         r.cx = 4'($urandom_range(grid_w - 1));
         r.cy = 4'($urandom_range(grid_h - 1));
         r.gx = 4'($urandom_range(grid_w - 1));
         r.gy = 4'($urandom_range(grid_h - 1));
      end
      k = $urandom_range(99);
      r.func = k < 40 ? FUNC_BLOCK : k < 60 ? FUNC_COST : k < 95 ? FUNC_PATH : FUNC_UNUSED;
      if (r.func == FUNC_BLOCK) r.blk = $urandom_range(99) < 30;
      if (r.func == FUNC_COST && $urandom_range(9) != 0)
         r.cost = 16'($urandom_range(256, $urandom_range(1) ? 1024 : 65535));
      return r;
   endfunction

   task automatic test_directed();
      send(mk(FUNC_PATH, 0, 0, 0, 0, 0, 0, 0));
      send(mk(FUNC_PATH, 0, 0, 0, 0, 7, 7, 0));
      send(mk(FUNC_PATH, 0, 0, 0, 0, 7, 7, 1));
      send(mk(FUNC_BLOCK, 3, 3, 1, 0, 0, 0, 0));
      send(mk(FUNC_BLOCK, 15, 15, 1, 16'hFFFF, 15, 15, 1));
      send(mk(FUNC_COST, 7, 7, 0, 16'hFFFF, 0, 0, 0));
      send(mk(FUNC_COST, 0, 0, 1, 16'd255, 0, 0, 0));
      send(mk(FUNC_COST, 1, 1, 0, 16'd256, 0, 0, 0));
      send(mk(FUNC_COST, 8, 0, 0, 16'd300, 0, 0, 0));
      send(mk(FUNC_UNUSED, 1, 1, 1, 16'd300, 1, 1, 1));
      send(mk(FUNC_PATH, 8, 0, 0, 0, 1, 1, 0));
      send(mk(FUNC_PATH, 0, 0, 0, 0, 0, 15, 0));
      send(mk(FUNC_PATH, 0, 0, 0, 0, 3, 3, 1));
      send(mk(FUNC_BLOCK, 0, 0, 1, 0, 0, 0, 0));
      send(mk(FUNC_PATH, 0, 0, 0, 0, 2, 0, 0));
      send(mk(FUNC_BLOCK, 1, 0, 1, 0, 0, 0, 0));
      send(mk(FUNC_PATH, 0, 0, 0, 0, 1, 1, 1));
      send(mk(FUNC_PATH, 7, 7, 0, 0, 0, 1, 1));
      drain();
   endtask

   task automatic test_config();
      csr_write(CSR_GRID_WIDTH, 4'd0);
      csr_write(CSR_GRID_HEIGHT, 4'd9);
      csr_write(CSR_GRID_WIDTH, 4'd15);
      send(mk(FUNC_PATH, 0, 0, 0, 0, 1, 0, 0));
      csr_write(CSR_GRID_WIDTH, 4'd1);
      csr_write(CSR_GRID_HEIGHT, 4'd1);
      send(mk(FUNC_PATH, 0, 0, 0, 0, 0, 0, 1));
      send(mk(FUNC_BLOCK, 1, 0, 1, 0, 0, 0, 0));
      csr_write(CSR_GRID_WIDTH, 4'd3);
      send(mk(FUNC_BLOCK, 1, 0, 1, 0, 0, 0, 0));
      send(mk(FUNC_PATH, 0, 0, 0, 0, 2, 0, 1));
      csr_write(CSR_GRID_WIDTH, 4'd8);
      csr_write(CSR_GRID_HEIGHT, 4'd8);
      send(mk(FUNC_PATH, 0, 7, 0, 0, 7, 0, 1));
      drain();
   endtask

   task automatic test_random();
      int dims [4][2] = '{'{8, 8}, '{3, 5}, '{8, 2}, '{6, 7}};
      foreach (dims[p]) begin
         csr_write(CSR_GRID_WIDTH, 4'(dims[p][0]));
         csr_write(CSR_GRID_HEIGHT, 4'(dims[p][1]));
         quiet = (p == 2);
         repeat (20) send(rand_req());
      end
      quiet = 0;
      drain();
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (20) send(mk(FUNC_BLOCK, $urandom_range(grid_w - 1), $urandom_range(grid_h - 1),
                          0, 0, 0, 0, 0));
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else
         rsp_ready <= quiet || $urandom_range(99) >= 33;
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_path_x, rsp_path_y, rsp_last};
         if (path_q.size() == 0) report($sformatf("unexpected result %p", got));
         else begin
            want = path_q.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.px !== want.px) report($sformatf("path_x %0d, want %0d", got.px, want.px));
            if (got.py !== want.py) report($sformatf("path_y %0d, want %0d", got.py, want.py));
            if (got.last !== want.last)
               report($sformatf("last %0d, want %0d", got.last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      grid_w = GRID_W_DEF;
      grid_h = GRID_H_DEF;
      clear_maps();
      repeat (6) @(posedge clock);
      reset <= 0;
      test_directed();
      test_config();
      test_backpressure();
      test_random();
      repeat (50) @(posedge clock);
      if (errors == 0 && path_q.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
